FILE: rtl/pdmeb_pkg.sv
// Shared constants, types and register codes of the PDM envelope blow detector.
package pdmeb_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int WORD_W     = 16;
    localparam int POP_W      = 5;
    localparam int SAMPLE_W   = 8;
    localparam int SLEVEL_W   = 32;
    localparam int ENV_W      = 40;
    localparam int WPB_W      = 8;
    localparam int BPW_W      = 16;
    localparam int THRESH_W   = 18;
    localparam int KEEP_W     = 16;
    localparam int KEEP_SHIFT = 16;

    localparam int OPND_W   = ENV_W + 1;
    localparam int MUL_LO_W = (OPND_W + 1) / 2;
    localparam int MUL_HI_W = OPND_W - MUL_LO_W;
    localparam int PROD_W   = MUL_LO_W + KEEP_W;
    localparam int FULL_W   = OPND_W + KEEP_SHIFT;

    localparam int PEAK_OUT_W   = 18;
    localparam int PEAK_OUT_MAX = 2 ** PEAK_OUT_W - 1;
    localparam int THR_CMP_W    = THRESH_W + FRACTION_BITS;
    localparam int CMP_W        = (THR_CMP_W > ENV_W) ? THR_CMP_W : ENV_W;

    localparam int OUT_TDATA_W = ((PEAK_OUT_W + 1 + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [WPB_W-1:0]    WPB_RESET  = WPB_W'(20);
    localparam logic [BPW_W-1:0]    BPW_RESET  = BPW_W'(2500);
    localparam logic [THRESH_W-1:0] THR_RESET  = THRESH_W'(70000);
    localparam logic [KEEP_W-1:0]   KEEP_RESET = KEEP_W'(62259);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WORDS_PER_BLOCK   = 8'd0,
        CFG_BLOCKS_PER_WINDOW = 8'd1,
        CFG_BLOW_THRESHOLD    = 8'd2,
        CFG_KEEP_RATE         = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WPB_W-1:0]    words_per_block;
        logic [BPW_W-1:0]    blocks_per_window;
        logic [THRESH_W-1:0] blow_threshold;
        logic [KEEP_W-1:0]   keep_rate;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ENV_SUM,
        ST_COUNT,
        ST_EMIT
    } back_state_t;

endpackage

FILE: rtl/pdm_envelope_blow_detector.sv
// Top level of the PDM envelope blow detector.
//
// The slave stream takes one 16-bit PDM word per item. Each word adds its
// wrapped popcount sample to two leaky integrators; after words_per_block
// words the envelope updates the peak, and after blocks_per_window blocks one
// item leaves on the master stream with the saturated peak integer part and
// the blow flag, and the peak is cleared.
// The configuration channel writes one register per handshake (index 0 words
// per block, 1 blocks per window, 2 blow threshold, 3 keep rate); cfg_ready is
// always high and writes belong in idle periods.
// The engine takes a new word only when it is through with the last one and
// the output register is empty. The shared 21x16 multiplier is used four times
// per word (two halves for each integrator); at the end of each window an emit
// state forms the result. A word that closes a window shows its result after it
// leaves the two-entry queue and passes the multiply, count and emit states.
// Reset clears the counters, the integrators, the peak, the queue and the
// output valid flag, and loads the register defaults.
// When the receiver stalls, the result holds in the output register; the
// engine stops taking words and the queue fills, then s_tready drops.
module pdm_envelope_blow_detector
    import pdmeb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_W-1:0]      s_tdata,     // [15:0] pdm_word
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,     // [17:0] peak_envelope, [18] blow_detected
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                cfg;
    logic                push_valid;
    logic                push_ready;
    logic [SAMPLE_W-1:0] push_data;
    logic                pop_valid;
    logic                pop_ready;
    logic [SAMPLE_W-1:0] pop_data;

    pdmeb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdmeb_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pdmeb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pdmeb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: rtl/pdmeb_cfg.sv
// Configuration register file of the PDM envelope blow detector.
module pdmeb_cfg
    import pdmeb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WORDS_PER_BLOCK:   cfg_next.words_per_block   = cfg_data[WPB_W-1:0];
                CFG_BLOCKS_PER_WINDOW: cfg_next.blocks_per_window = cfg_data[BPW_W-1:0];
                CFG_BLOW_THRESHOLD:    cfg_next.blow_threshold    = cfg_data[THRESH_W-1:0];
                CFG_KEEP_RATE:         cfg_next.keep_rate         = cfg_data[KEEP_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words_per_block   <= WPB_RESET;
            cfg_reg.blocks_per_window <= BPW_RESET;
            cfg_reg.blow_threshold    <= THR_RESET;
            cfg_reg.keep_rate         <= KEEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/pdmeb_front.sv
// Input side: accept PDM words and reduce each to its wrapped popcount sample.
module pdmeb_front
    import pdmeb_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,     // [15:0] pdm_word
    output logic                push_valid,
    input  logic                push_ready,
    output logic [SAMPLE_W-1:0] push_data
);

    logic [1:0] sum2 [8];
    logic [2:0] sum3 [4];
    logic [3:0] sum4 [2];
    logic [POP_W-1:0] ones;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sum2[i] = {1'b0, s_tdata[2*i]} + {1'b0, s_tdata[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            sum3[i] = {1'b0, sum2[2*i]} + {1'b0, sum2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            sum4[i] = {1'b0, sum3[2*i]} + {1'b0, sum3[2*i+1]};
        end
        ones = {1'b0, sum4[0]} + {1'b0, sum4[1]};
    end

    assign push_data  = SAMPLE_W'(ones) - SAMPLE_W'(8);
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

FILE: rtl/pdmeb_queue.sv
// Short sample queue between the input side and the integrator engine.
module pdmeb_queue
    import pdmeb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  logic [SAMPLE_W-1:0] push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output logic [SAMPLE_W-1:0] pop_data
);

    logic [SAMPLE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/pdmeb_back.sv
// Integrator engine: two leaky integrators on a shared multiplier, block and window logic.
module pdmeb_back
    import pdmeb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [SAMPLE_W-1:0]    pop_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    back_state_t state_reg;
    back_state_t state_next;

    logic                   phase_reg;
    logic                   phase_next;
    logic [OPND_W-1:0]      opnd_reg;
    logic [OPND_W-1:0]      opnd_next;
    logic [PROD_W-1:0]      acc_reg;
    logic [PROD_W-1:0]      acc_next;
    logic [SLEVEL_W-1:0]    slevel_reg;
    logic [SLEVEL_W-1:0]    slevel_next;
    logic [ENV_W-1:0]       env_reg;
    logic [ENV_W-1:0]       env_next;
    logic [ENV_W-1:0]       peak_reg;
    logic [ENV_W-1:0]       peak_next;
    logic [WPB_W-1:0]       word_count_reg;
    logic [WPB_W-1:0]       word_count_next;
    logic [BPW_W-1:0]       block_count_reg;
    logic [BPW_W-1:0]       block_count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;

    logic                   take;
    logic [OPND_W-1:0]      sample_sum;
    logic [OPND_W-1:0]      env_sum;
    logic [MUL_LO_W-1:0]    mul_a;
    logic [PROD_W-1:0]      prod;
    logic [FULL_W-1:0]      full;
    logic [OPND_W-1:0]      leaked;
    logic [SLEVEL_W-1:0]    slevel_sat;
    logic [ENV_W-1:0]       env_sat;
    logic [WPB_W-1:0]       word_inc;
    logic [BPW_W-1:0]       block_inc;
    logic                   block_end;
    logic                   window_end;
    logic [ENV_W-1:0]       peak_max;
    logic [ENV_W-1:0]       peak_shift;
    logic [PEAK_OUT_W-1:0]  peak_int;
    logic                   blow;

    assign take = pop_valid && pop_ready;

    assign sample_sum = OPND_W'(slevel_reg) + (OPND_W'(pop_data) << FRACTION_BITS);
    assign env_sum    = OPND_W'(env_reg) + OPND_W'(slevel_reg);

    assign mul_a  = (state_reg == ST_MUL_LO) ? opnd_reg[MUL_LO_W-1:0]
                                             : MUL_LO_W'(opnd_reg[OPND_W-1:MUL_LO_W]);
    assign prod   = PROD_W'(mul_a) * PROD_W'(cfg.keep_rate);
    assign full   = FULL_W'(acc_reg) + (FULL_W'(prod) << MUL_LO_W);
    assign leaked = full[FULL_W-1:KEEP_SHIFT];

    assign slevel_sat = (|leaked[OPND_W-1:SLEVEL_W]) ? '1 : leaked[SLEVEL_W-1:0];
    assign env_sat    = leaked[OPND_W-1] ? '1 : leaked[ENV_W-1:0];

    assign word_inc   = word_count_reg + 1'b1;
    assign block_inc  = block_count_reg + 1'b1;
    assign block_end  = (word_inc == cfg.words_per_block);
    assign window_end = (block_inc == cfg.blocks_per_window);
    assign peak_max   = (env_reg > peak_reg) ? env_reg : peak_reg;

    assign peak_shift = peak_reg >> FRACTION_BITS;
    assign peak_int   = (peak_shift > ENV_W'(PEAK_OUT_MAX)) ? PEAK_OUT_W'(PEAK_OUT_MAX)
                                                           : peak_shift[PEAK_OUT_W-1:0];
    assign blow       = CMP_W'(peak_reg) > (CMP_W'(cfg.blow_threshold) << FRACTION_BITS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    state_next = take ? ST_MUL_LO : ST_IDLE;
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = phase_reg ? ST_COUNT : ST_ENV_SUM;
            ST_ENV_SUM: state_next = ST_MUL_LO;
            ST_COUNT:   state_next = (block_end && window_end) ? ST_EMIT : ST_IDLE;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = (state_reg == ST_IDLE) && !m_valid_reg;
        m_tvalid  = m_valid_reg;
        m_tdata   = m_data_reg;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        opnd_next        = opnd_reg;
        acc_next         = acc_reg;
        slevel_next      = slevel_reg;
        env_next         = env_reg;
        peak_next        = peak_reg;
        word_count_next  = word_count_reg;
        block_count_next = block_count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    phase_next = 1'b0;
                    opnd_next  = sample_sum;
                end
            end
            ST_MUL_LO:
            begin
                acc_next = prod;
            end
            ST_MUL_HI:
            begin
                if (phase_reg)
                begin
                    env_next = env_sat;
                end
                else
                begin
                    slevel_next = slevel_sat;
                end
            end
            ST_ENV_SUM:
            begin
                phase_next = 1'b1;
                opnd_next  = env_sum;
            end
            ST_COUNT:
            begin
                if (block_end)
                begin
                    word_count_next  = '0;
                    peak_next        = peak_max;
                    block_count_next = window_end ? '0 : block_inc;
                end
                else
                begin
                    word_count_next = word_inc;
                end
            end
            ST_EMIT:
            begin
                m_valid_next = 1'b1;
                m_data_next  = OUT_TDATA_W'({blow, peak_int});
                peak_next    = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            slevel_reg      <= '0;
            env_reg         <= '0;
            peak_reg        <= '0;
            word_count_reg  <= '0;
            block_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            slevel_reg      <= slevel_next;
            env_reg         <= env_next;
            peak_reg        <= peak_next;
            word_count_reg  <= word_count_next;
            block_count_reg <= block_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg   <= opnd_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/pdmeb_checker.sv
// Port-level checks of the PDM envelope blow detector, bound to the top level.
module pdmeb_checker
    import pdmeb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
    else $error("result valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:PEAK_OUT_W+1] == '0))
    else $error("padding bits of result not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind pdm_envelope_blow_detector pdmeb_checker u_checker (.*);

FILE: tb/pdm_envelope_blow_detector_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for pdm_envelope_blow_detector with its own envelope predictor.
module pdm_envelope_blow_detector_test;
    import pdmeb_pkg::*;

    localparam int MAX_WAIT      = 11;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [63:0] SAMPLE_CAP = (64'd1 << SLEVEL_W) - 64'd1;
    localparam logic [63:0] ENV_CAP    = (64'd1 << ENV_W) - 64'd1;

    localparam logic [BPW_W-1:0]       BPW_FULL           = '1;
    localparam logic [THRESH_W-1:0]    THR_FULL           = '1;
    localparam logic [KEEP_W-1:0]      KEEP_FULL          = '1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNMAPPED = CFG_INDEX_W'(CFG_KEEP_RATE + 1);
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX     = '1;

    typedef struct packed {
        logic [PEAK_OUT_W-1:0] peak_envelope;
        logic                  blow_detected;
    } window_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b1;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [WPB_W-1:0]    words_per_block_reg   = WPB_RESET;
    logic [BPW_W-1:0]    blocks_per_window_reg = BPW_RESET;
    logic [THRESH_W-1:0] threshold_reg         = THR_RESET;
    logic [KEEP_W-1:0]   keep_reg              = KEEP_RESET;
    logic [WPB_W-1:0]    word_index            = '0;
    logic [BPW_W-1:0]    block_index           = '0;
    logic [SLEVEL_W-1:0] sample_level          = '0;
    logic [ENV_W-1:0]    envelope_level        = '0;
    logic [ENV_W-1:0]    peak_level            = '0;

    window_result_t expected_windows[$];

    int words_sent        = 0;
    int windows_predicted = 0;
    int windows_checked   = 0;
    int reg_writes        = 0;
    int error_count       = 0;
    bit no_idle           = 1'b0;

    pdm_envelope_blow_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic track_word(input logic [WORD_W-1:0] word);
        logic [SAMPLE_W-1:0] pcm_sample;
        logic [63:0]         leaked;
        logic [ENV_W-1:0]    peak_int;
        window_result_t      result;
        pcm_sample = SAMPLE_W'($countones(word) - 8);
        leaked = ((64'(sample_level) + (64'(pcm_sample) << FRACTION_BITS)) * 64'(keep_reg))
                 >> KEEP_SHIFT;
        sample_level = (leaked > SAMPLE_CAP) ? SAMPLE_CAP[SLEVEL_W-1:0] : leaked[SLEVEL_W-1:0];
        leaked = ((64'(envelope_level) + 64'(sample_level)) * 64'(keep_reg)) >> KEEP_SHIFT;
        envelope_level = (leaked > ENV_CAP) ? ENV_CAP[ENV_W-1:0] : leaked[ENV_W-1:0];
        word_index = word_index + 1'b1;
        if (word_index == words_per_block_reg)
        begin
            word_index = '0;
            if (envelope_level > peak_level)
                peak_level = envelope_level;
            block_index = block_index + 1'b1;
            if (block_index == blocks_per_window_reg)
            begin
                block_index = '0;
                peak_int = peak_level >> FRACTION_BITS;
                result.peak_envelope = (peak_int > PEAK_OUT_MAX) ? PEAK_OUT_W'(PEAK_OUT_MAX)
                                                                 : peak_int[PEAK_OUT_W-1:0];
                result.blow_detected = 64'(peak_level) > (64'(threshold_reg) << FRACTION_BITS);
                expected_windows.push_back(result);
                windows_predicted++;
                peak_level = '0;
            end
        end
    endtask

    function automatic logic [WORD_W-1:0] loud_word();
        return WORD_W'($urandom & $urandom & $urandom);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 2))
            0:       return WORD_W'($urandom);
            1:       return WORD_W'($urandom | $urandom);
            default: return loud_word();
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (s_tready !== 1'b1);
        words_sent++;
        track_word(word);
    endtask

    task automatic run_windows(input int count, input bit loud_only);
        int target;
        target = windows_predicted + count;
        while (windows_predicted < target)
            send_word(loud_only ? loud_word() : pick_word());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        reg_writes++;
        case (index)
            CFG_WORDS_PER_BLOCK:   words_per_block_reg   = value[WPB_W-1:0];
            CFG_BLOCKS_PER_WINDOW: blocks_per_window_reg = value[BPW_W-1:0];
            CFG_BLOW_THRESHOLD:    threshold_reg         = value[THRESH_W-1:0];
            CFG_KEEP_RATE:         keep_reg              = value[KEEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [WPB_W-1:0]    wpb,
                             input logic [BPW_W-1:0]    bpw,
                             input logic [THRESH_W-1:0] thr,
                             input logic [KEEP_W-1:0]   keep);
        logic [CFG_DATA_W-1:0] noise;
        noise = $urandom;
        write_reg(CFG_WORDS_PER_BLOCK, {noise[CFG_DATA_W-1:WPB_W], wpb});
        noise = $urandom;
        write_reg(CFG_BLOCKS_PER_WINDOW, {noise[CFG_DATA_W-1:BPW_W], bpw});
        noise = $urandom;
        write_reg(CFG_BLOW_THRESHOLD, {noise[CFG_DATA_W-1:THRESH_W], thr});
        noise = $urandom;
        write_reg(CFG_KEEP_RATE, {noise[CFG_DATA_W-1:KEEP_W], keep});
    endtask

    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A default window is far too long to finish, so no item may come out here.
    task automatic test_reset_defaults();
        repeat (12) send_word(pick_word());
        settle();
    endtask

    task automatic test_lowered_block_size();
        configure(WPB_W'(5), BPW_W'(1), THRESH_W'($urandom_range(0, 100000)), KEEP_FULL);
        run_windows(1, 1'b1);
        settle();
    endtask

    // One 256-word block; the levels carry over from the previous test and saturate.
    task automatic test_integrator_saturation();
        configure(WPB_W'(0), BPW_W'(1), THR_FULL, KEEP_FULL);
        run_windows(1, 1'b1);
        settle();
    endtask

    task automatic test_field_extremes();
        configure(WPB_W'(1), BPW_W'(1), THRESH_W'(0), KEEP_RESET);
        for (int ones = 0; ones <= WORD_W; ones++)
            send_word(WORD_W'((17'd1 << ones) - 17'd1));
        send_word(WORD_W'(16'h5555));
        send_word(WORD_W'(16'hAAAA));
        settle();
    endtask

    task automatic test_zero_keep_rate();
        configure(WPB_W'(2), BPW_W'(2), THRESH_W'(0), KEEP_W'(0));
        run_windows(2, 1'b1);
        settle();
    endtask

    task automatic test_zero_window_length();
        configure(WPB_W'(1), BPW_W'(0), THRESH_W'($urandom_range(0, 100000)), KEEP_RESET);
        repeat (3) send_word(pick_word());
        settle();
        write_reg(CFG_BLOCKS_PER_WINDOW, CFG_DATA_W'(BPW_FULL));
        repeat (2) send_word(pick_word());
        settle();
        write_reg(CFG_BLOCKS_PER_WINDOW, CFG_DATA_W'(7));
        run_windows(1, 1'b0);
        settle();
    endtask

    task automatic test_random_windows(input int word_budget);
        int                  stop_at;
        logic [WPB_W-1:0]    wpb;
        logic [BPW_W-1:0]    bpw;
        logic [THRESH_W-1:0] thr;
        logic [KEEP_W-1:0]   keep;
        stop_at = words_sent + word_budget;
        while (words_sent < stop_at)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            wpb = ($urandom_range(0, 7) == 0) ? WPB_W'($urandom_range(7, 24))
                                              : WPB_W'($urandom_range(1, 6));
            bpw = ($urandom_range(0, 7) == 0) ? BPW_W'($urandom_range(6, 12))
                                              : BPW_W'($urandom_range(1, 5));
            case ($urandom_range(0, 5))
                0:       thr = '0;
                1:       thr = THR_FULL;
                default: thr = THRESH_W'($urandom_range(0, 120000));
            endcase
            case ($urandom_range(0, 5))
                0:       keep = '0;
                1:       keep = KEEP_FULL;
                2:       keep = KEEP_RESET;
                default: keep = KEEP_W'($urandom_range(0, 65535));
            endcase
            configure(wpb, bpw, thr, keep);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_INDEX)),
                          CFG_DATA_W'($urandom));
            run_windows((int'(wpb) * int'(bpw) > 40) ? 1 : $urandom_range(1, 4), 1'b0);
            settle();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_checker
        window_result_t        want;
        logic [PEAK_OUT_W-1:0] got_peak;
        logic                  got_blow;
        int                    stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got_peak = m_tdata[PEAK_OUT_W-1:0];
            got_blow = m_tdata[PEAK_OUT_W];
            if (expected_windows.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected item, peak_envelope %0d blow_detected %0b",
                         $time, got_peak, got_blow);
            end
            else
            begin
                want = expected_windows.pop_front();
                windows_checked++;
                if (got_peak !== want.peak_envelope)
                begin
                    error_count++;
                    $display("%0t: peak_envelope expected %0d actual %0d",
                             $time, want.peak_envelope, got_peak);
                end
                if (got_blow !== want.blow_detected)
                begin
                    error_count++;
                    $display("%0t: blow_detected expected %0b actual %0b",
                             $time, want.blow_detected, got_blow);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[pdm_envelope_blow_detector] ERROR");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_lowered_block_size();
        test_integrator_saturation();
        test_field_extremes();
        test_zero_keep_rate();
        test_zero_window_length();
        test_random_windows(150);
        settle();
        $display("Sent %0d PDM words and %0d register writes; checked %0d window results.",
                 words_sent, reg_writes, windows_checked);
        $display("Covered 1..256-word blocks, zero and full keep rates, saturated levels.");
        if (error_count == 0)
            $display("[pdm_envelope_blow_detector] OK");
        else
            $display("[pdm_envelope_blow_detector] ERROR");
        $finish;
    end

endmodule

FILE: pdm_envelope_blow_detector.f
rtl/pdmeb_pkg.sv
rtl/pdmeb_cfg.sv
rtl/pdmeb_front.sv
rtl/pdmeb_queue.sv
rtl/pdmeb_back.sv
rtl/pdm_envelope_blow_detector.sv
rtl/pdmeb_checker.sv
tb/pdm_envelope_blow_detector_test.sv
